// ===== rtl/core/wtm_pkg.sv =====
package wtm_pkg;

  localparam int CHAR_W          = 8;
  localparam int LEN_W           = 6;
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = 64;
  localparam int NUM_WORDS       = 4;
  localparam int BYTES_PER_WORD  = 8;
  localparam int MAX_PATTERN_DEF = 32;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_WORD0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WORD1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WORD2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WORD3 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LEN   = 3'd4;

  localparam logic [CHAR_W-1:0] CHAR_STAR  = 8'h2A;
  localparam logic [CHAR_W-1:0] CHAR_QMARK = 8'h3F;
  localparam logic [CHAR_W-1:0] CHAR_UC_A  = 8'h41;
  localparam logic [CHAR_W-1:0] CHAR_UC_Z  = 8'h5A;
  localparam logic [CHAR_W-1:0] CASE_DIFF  = 8'h20;

  // decoded view of one pattern position
  typedef struct packed {
    logic              en;     // position lies inside the pattern length
    logic              star;   // '*' inside the pattern
    logic              qm;     // '?' inside the pattern
    logic [CHAR_W-1:0] pchar;  // lower-cased pattern byte
  } pos_t;

  function automatic logic [CHAR_W-1:0] fold(input logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] r;
    r = c;
    if (c inside {[CHAR_UC_A:CHAR_UC_Z]}) begin
      r = c + CASE_DIFF;
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/wtm_cfg.sv =====
module wtm_cfg #(
  parameter int MAX_PATTERN = wtm_pkg::MAX_PATTERN_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [wtm_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [wtm_pkg::CFG_DATA_W-1:0]      cfg_wdata_i,
  output wtm_pkg::pos_t [MAX_PATTERN-1:0]     pos_o,
  output logic                                wild_o,
  output logic [MAX_PATTERN:0]                fin_o,
  output logic [MAX_PATTERN:0]                start_o,
  output logic                                pend_o
);

  localparam logic [wtm_pkg::LEN_W-1:0] MaxLen = wtm_pkg::LEN_W'(MAX_PATTERN);

  logic [wtm_pkg::CFG_DATA_W-1:0] word_q [wtm_pkg::NUM_WORDS];
  logic [wtm_pkg::LEN_W-1:0]      len_q;
  logic                           pend_q, pend_d;
  logic [wtm_pkg::LEN_W-1:0]      len_eff;

  wtm_pkg::pos_t [MAX_PATTERN-1:0] pos_d, pos_q;
  logic [MAX_PATTERN-1:0]          star_c, qm_c;
  logic                            wild_d, wild_q;
  logic [MAX_PATTERN:0]            fin_d, fin_q, start_d, start_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int w = 0; w < wtm_pkg::NUM_WORDS; w++) begin
        word_q[w] <= '0;
      end
      len_q  <= '0;
      pend_q <= 1'b1;
    end else begin
      pend_q <= pend_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          wtm_pkg::REG_WORD0, wtm_pkg::REG_WORD1,
          wtm_pkg::REG_WORD2, wtm_pkg::REG_WORD3: begin
            word_q[cfg_idx_i[1:0]] <= cfg_wdata_i;
          end
          wtm_pkg::REG_LEN: begin
            len_q <= cfg_wdata_i[wtm_pkg::LEN_W-1:0];
          end
          default: ;
        endcase
      end
    end
  end

  // hold the input off after a write to a defined register while the decoded pattern catches up
  assign pend_d  = cfg_we_i && (cfg_idx_i <= wtm_pkg::REG_LEN);
  assign len_eff = (len_q > MaxLen) ? MaxLen : len_q;

  for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_pos
    localparam int W = i / wtm_pkg::BYTES_PER_WORD;
    localparam int B = i % wtm_pkg::BYTES_PER_WORD;
    logic [wtm_pkg::CHAR_W-1:0] pbyte;
    assign pbyte           = word_q[W][B*wtm_pkg::CHAR_W +: wtm_pkg::CHAR_W];
    assign pos_d[i].en     = wtm_pkg::LEN_W'(i) < len_eff;
    assign pos_d[i].star   = pos_d[i].en && (pbyte == wtm_pkg::CHAR_STAR);
    assign pos_d[i].qm     = pos_d[i].en && (pbyte == wtm_pkg::CHAR_QMARK);
    assign pos_d[i].pchar  = wtm_pkg::fold(pbyte);
    assign star_c[i]       = pos_d[i].star;
    assign qm_c[i]         = pos_d[i].qm;
  end

  assign wild_d = |(star_c | qm_c);

  // start vector: empty prefix plus every prefix reached over leading stars
  assign start_d[0] = 1'b1;
  for (genvar k = 1; k <= MAX_PATTERN; k++) begin : g_start
    assign start_d[k] = &star_c[k-1:0];
  end

  for (genvar k = 0; k <= MAX_PATTERN; k++) begin : g_fin
    assign fin_d[k] = (len_eff == wtm_pkg::LEN_W'(k));
  end

  always_ff @(posedge clk_i) begin
    pos_q   <= pos_d;
    wild_q  <= wild_d;
    fin_q   <= fin_d;
    start_q <= start_d;
  end

  assign pos_o   = pos_q;
  assign wild_o  = wild_q;
  assign fin_o   = fin_q;
  assign start_o = start_q;
  assign pend_o  = pend_q;

endmodule

// ===== rtl/core/wtm_cell.sv =====
module wtm_cell (
  input  logic                        clk_i,
  input  wtm_pkg::pos_t               pos_i,
  input  logic [wtm_pkg::CHAR_W-1:0]  ch_i,
  input  logic                        restart_i,
  input  logic                        start_i,
  input  logic                        seed_i,
  input  logic                        hold_i,
  input  logic                        load_i,
  input  logic                        adv_i,
  input  logic                        carry_i,
  output logic                        adv_o,
  output logic                        carry_o,
  output logic                        nv_o
);

  logic s_q, s_d;
  logic v, hit, self_keep, clos;

  assign v         = restart_i ? start_i : s_q;
  assign hit       = pos_i.en && !pos_i.star && (pos_i.qm || (pos_i.pchar == ch_i));
  // advance the neighbor's prefix on a consumed byte
  assign adv_o     = v && hit;
  // stay on a star that swallows the byte
  assign self_keep = v && pos_i.star;
  assign clos      = self_keep || adv_i || carry_i;
  // pass the star closure on to the next cell
  assign carry_o   = clos && pos_i.star;
  assign s_d       = clos || seed_i || (v && hold_i);
  assign nv_o      = s_d;

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      s_q <= s_d;
    end
  end

endmodule

// ===== rtl/core/wildcard_text_matcher.sv =====
// Channel   | Handshake                    | Payload
// ----------+------------------------------+-------------------------------------
// input     | in_valid_i / in_stall_o      | text_char_i, last_char_i, empty_text_i
// output    | out_valid_o / out_stall_i    | match_o
// config    | cfg_we_i (no wait)           | cfg_idx_i, cfg_wdata_i
//
// One item per cycle while the input is not stalled: the prefix vector updates
// in a single pass through the row of cells, and the star closure ripples cell
// to cell in the same cycle. A result is registered in the output register; a
// skid register lets the input run on while the output is stalled, until the
// skid slot fills. Reset loads an empty pattern; the input stalls after reset
// and after every write to a defined register while the decoded pattern refreshes.
module wildcard_text_matcher #(
  parameter int MAX_PATTERN = wtm_pkg::MAX_PATTERN_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [wtm_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [wtm_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [wtm_pkg::CHAR_W-1:0]      text_char_i,
  input  logic                            last_char_i,
  input  logic                            empty_text_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic                            match_o
);

  wtm_pkg::pos_t [MAX_PATTERN-1:0] pos;
  logic                            wild;
  logic [MAX_PATTERN:0]            fin, start_vec, nv_all;
  logic                            pend;

  logic [MAX_PATTERN-1:0]          adv, carry;
  logic [wtm_pkg::CHAR_W-1:0]      ch_fold;
  logic                            in_acc, load, cfg_hit;
  logic                            restart_q, restart_d;
  logic                            top_q, top_v;
  logic                            res_valid, res_match, out_take;
  logic                            out_valid_q, skid_valid_q;
  logic                            out_match_q, skid_match_q;

  wtm_cfg #(
    .MAX_PATTERN (MAX_PATTERN)
  ) u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .pos_o       (pos),
    .wild_o      (wild),
    .fin_o       (fin),
    .start_o     (start_vec),
    .pend_o      (pend)
  );

  // accept nothing while the pattern decode refreshes or the skid slot is full
  assign in_stall_o = pend || skid_valid_q;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign load       = in_acc && !empty_text_i;
  assign cfg_hit    = cfg_we_i && (cfg_idx_i <= wtm_pkg::REG_LEN);
  assign ch_fold    = wtm_pkg::fold(text_char_i);

  // Row of cells: cell i holds prefix bit i. Without wildcards, cell 0 is
  // reseeded every byte (a match may start anywhere) and the cell at the
  // pattern length latches a found occurrence.
  for (genvar g = 0; g < MAX_PATTERN; g++) begin : g_cell
    logic adv_in, carry_in, seed;
    if (g == 0) begin : g_head
      assign adv_in   = 1'b0;
      assign carry_in = 1'b0;
      assign seed     = !wild;
    end else begin : g_body
      assign adv_in   = adv[g-1];
      assign carry_in = carry[g-1];
      assign seed     = 1'b0;
    end
    wtm_cell u_cell (
      .clk_i     (clk_i),
      .pos_i     (pos[g]),
      .ch_i      (ch_fold),
      .restart_i (restart_q),
      .start_i   (start_vec[g]),
      .seed_i    (seed),
      .hold_i    (fin[g] && !wild),
      .load_i    (load),
      .adv_i     (adv_in),
      .carry_i   (carry_in),
      .adv_o     (adv[g]),
      .carry_o   (carry[g]),
      .nv_o      (nv_all[g])
    );
  end

  // the full-length prefix bit sits past the last cell
  assign top_v = restart_q ? start_vec[MAX_PATTERN] : top_q;
  assign nv_all[MAX_PATTERN] = adv[MAX_PATTERN-1] || carry[MAX_PATTERN-1] ||
                               (top_v && fin[MAX_PATTERN] && !wild);

  always_ff @(posedge clk_i) begin
    if (load) begin
      top_q <= nv_all[MAX_PATTERN];
    end
  end

  // restart after a result, and after any write to a defined register
  always_comb begin
    restart_d = restart_q;
    if (cfg_hit) begin
      restart_d = 1'b1;
    end else if (in_acc) begin
      restart_d = last_char_i || empty_text_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      restart_q <= 1'b1;
    end else begin
      restart_q <= restart_d;
    end
  end

  assign res_valid = in_acc && (last_char_i || empty_text_i);
  assign res_match = empty_text_i ? |(start_vec & fin) : |(nv_all & fin);
  assign out_take  = out_valid_q && !out_stall_i;

  // output register with a skid slot behind it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_take) begin
        skid_valid_q <= 1'b0;
      end
    end else if (res_valid) begin
      if (!out_valid_q || out_take) begin
        out_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end else if (out_take) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_take) begin
        out_match_q <= skid_match_q;
      end
    end else if (res_valid) begin
      if (!out_valid_q || out_take) begin
        out_match_q <= res_match;
      end else begin
        skid_match_q <= res_match;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign match_o     = out_match_q;

  a_skid_behind_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid slot holds an item while the output register is empty");

  a_cfg_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_hit |=> in_stall_o)
    else $error("input not stalled after a pattern register write");

  a_fin_onehot : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |-> ($onehot(fin) && start_vec[0]))
    else $error("decoded pattern not settled when an item was accepted");

endmodule

// ===== tb/wildcard_text_matcher_test.sv =====
`timescale 1ns / 100ps

module wildcard_text_matcher_test;

  localparam int CHAR_W         = wtm_pkg::CHAR_W;
  localparam int LEN_W          = wtm_pkg::LEN_W;
  localparam int CFG_IDX_W      = wtm_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W     = wtm_pkg::CFG_DATA_W;
  localparam int NUM_WORDS      = wtm_pkg::NUM_WORDS;
  localparam int BYTES_PER_WORD = wtm_pkg::BYTES_PER_WORD;

  localparam logic [CFG_IDX_W-1:0] REG_WORD0 = wtm_pkg::REG_WORD0;
  localparam logic [CFG_IDX_W-1:0] REG_WORD1 = wtm_pkg::REG_WORD1;
  localparam logic [CFG_IDX_W-1:0] REG_WORD2 = wtm_pkg::REG_WORD2;
  localparam logic [CFG_IDX_W-1:0] REG_WORD3 = wtm_pkg::REG_WORD3;
  localparam logic [CFG_IDX_W-1:0] REG_LEN   = wtm_pkg::REG_LEN;

  localparam logic [CHAR_W-1:0] CHAR_STAR  = wtm_pkg::CHAR_STAR;
  localparam logic [CHAR_W-1:0] CHAR_QMARK = wtm_pkg::CHAR_QMARK;
  localparam logic [CHAR_W-1:0] CHAR_UC_A  = wtm_pkg::CHAR_UC_A;
  localparam logic [CHAR_W-1:0] CHAR_UC_Z  = wtm_pkg::CHAR_UC_Z;
  localparam logic [CHAR_W-1:0] CASE_DIFF  = wtm_pkg::CASE_DIFF;

  localparam int MAX_PAT        = wtm_pkg::MAX_PATTERN_DEF;
  localparam int RANDOM_ITEMS   = 1800;
  localparam int SETTLE_CYCLES  = 4;
  localparam int END_CYCLES     = 10;
  localparam int CYCLE_LIMIT    = 400000;

  // indexes 5..7 decode to no register
  localparam logic [CFG_IDX_W-1:0] FIRST_UNUSED_REG = REG_LEN + 3'd1;

  // '#' in a directed row stands for a zero byte, which a string cannot hold
  localparam logic [CHAR_W-1:0] NUL_STANDIN = 8'h23;
  localparam string TEXT_ALPHABET = "abcABC*?";
  localparam int    NUM_LETTERS   = 6;

  typedef enum logic [1:0] {ROW_PATTERN, ROW_TEXT, ROW_OPEN, ROW_EMPTY} row_kind_e;
  typedef enum logic [1:0] {ANSWER_MODEL, ANSWER_NO, ANSWER_YES} answer_e;

  typedef struct {
    row_kind_e kind;
    string     bytes;
    int        length;   // pattern rows only
    answer_e   answer;
  } stim_row_t;

  localparam int NUM_ROWS = 22;

  // Directed rows. ROW_OPEN sends bytes without closing the text.
  stim_row_t stim_rows [NUM_ROWS] = '{
    // after reset: empty pattern accepts everything
    '{ROW_EMPTY,   "",      0,  ANSWER_YES},
    '{ROW_TEXT,    "\377",  0,  ANSWER_YES},
    // containment, case-insensitive
    '{ROW_PATTERN, "aB",    2,  ANSWER_MODEL},
    '{ROW_TEXT,    "xAb",   0,  ANSWER_YES},
    '{ROW_EMPTY,   "",      0,  ANSWER_NO},
    '{ROW_TEXT,    "ba",    0,  ANSWER_NO},
    // wildcards; the trailing star lies beyond the length and must not count
    '{ROW_PATTERN, "a*?c*", 4,  ANSWER_MODEL},
    '{ROW_TEXT,    "AxyC",  0,  ANSWER_MODEL},
    '{ROW_TEXT,    "ac",    0,  ANSWER_MODEL},
    // zero and all-ones bytes are ordinary bytes
    '{ROW_PATTERN, "#\377", 2,  ANSWER_MODEL},
    '{ROW_TEXT,    "#\377", 0,  ANSWER_YES},
    // oversized length clamps to a full pattern of stars
    '{ROW_PATTERN, "********************************", 63, ANSWER_MODEL},
    '{ROW_EMPTY,   "",      0,  ANSWER_YES},
    '{ROW_TEXT,    "q",     0,  ANSWER_YES},
    // single '?' never matches an empty text
    '{ROW_PATTERN, "?",     1,  ANSWER_MODEL},
    '{ROW_EMPTY,   "",      0,  ANSWER_NO},
    // register write drops the open text
    '{ROW_OPEN,    "k",     0,  ANSWER_MODEL},
    '{ROW_PATTERN, "?",     1,  ANSWER_MODEL},
    '{ROW_TEXT,    "Z",     0,  ANSWER_MODEL},
    // empty item abandons the open text
    '{ROW_OPEN,    "k",     0,  ANSWER_MODEL},
    '{ROW_EMPTY,   "",      0,  ANSWER_NO},
    // non-ASCII bytes are not case folded
    '{ROW_PATTERN, "\301",  1,  ANSWER_MODEL}
  };

  logic                  clk_i        = 1'b0;
  logic                  rst_ni       = 1'b0;
  logic                  cfg_we_i     = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i    = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i  = '0;
  logic                  in_valid_i   = 1'b0;
  logic                  in_stall_o;
  logic [CHAR_W-1:0]     text_char_i  = '0;
  logic                  last_char_i  = 1'b0;
  logic                  empty_text_i = 1'b0;
  logic                  out_valid_o;
  logic                  out_stall_i  = 1'b0;
  logic                  match_o;

  wildcard_text_matcher uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .text_char_i  (text_char_i),
    .last_char_i  (last_char_i),
    .empty_text_i (empty_text_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .match_o      (match_o)
  );

  always #6 clk_i = ~clk_i;

  // Shadow of the pattern registers and the reachable-prefix vector
  logic [CFG_DATA_W-1:0] pat_words [NUM_WORDS] = '{default: '0};
  logic [LEN_W-1:0]      pat_len_reg   = '0;
  logic [MAX_PAT:0]      live_prefixes = 1;

  bit   match_expected_q [$];
  int   error_count = 0;
  int   items_sent  = 0;
  int   cycle_count = 0;
  bit   no_idle     = 1'b0;

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    error_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  function automatic int used_len();
    return (int'(pat_len_reg) > MAX_PAT) ? MAX_PAT : int'(pat_len_reg);
  endfunction

  function automatic logic [CHAR_W-1:0] pattern_at(input int i);
    return pat_words[i / BYTES_PER_WORD][(i % BYTES_PER_WORD) * CHAR_W +: CHAR_W];
  endfunction

  function automatic logic [CHAR_W-1:0] lower_ascii(input logic [CHAR_W-1:0] c);
    return (c >= CHAR_UC_A && c <= CHAR_UC_Z) ? c + CASE_DIFF : c;
  endfunction

  function automatic bit has_wildcards(input int n);
    bit wild;
    wild = 1'b0;
    for (int i = 0; i < n; i++) begin
      if (pattern_at(i) == CHAR_STAR || pattern_at(i) == CHAR_QMARK) begin
        wild = 1'b1;
      end
    end
    return wild;
  endfunction

  // a live prefix ending just before a star also reaches past the star
  function automatic logic [MAX_PAT:0] close_stars(input logic [MAX_PAT:0] v, input int n);
    for (int i = 0; i < n; i++) begin
      if (v[i] && pattern_at(i) == CHAR_STAR) begin
        v[i+1] = 1'b1;
      end
    end
    return v;
  endfunction

  function automatic logic [MAX_PAT:0] start_prefixes(input int n);
    return has_wildcards(n) ? close_stars(1, n) : 1;
  endfunction

  function automatic void restart_matcher();
    live_prefixes = start_prefixes(used_len());
  endfunction

  function automatic void apply_write(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_WORD0, REG_WORD1, REG_WORD2, REG_WORD3: begin
        pat_words[idx[1:0]] = data;
        restart_matcher();
      end
      REG_LEN: begin
        pat_len_reg = data[LEN_W-1:0];
        restart_matcher();
      end
      default: ;
    endcase
  endfunction

  // Advance by one item; flag whether it closes a text and return the answer.
  function automatic bit step_matcher(input logic [CHAR_W-1:0] ch, input bit last,
                                      input bit empty, output bit produced);
    int               n;
    bit               wild;
    bit               hit;
    logic [MAX_PAT:0] fin;
    logic [MAX_PAT:0] v;
    logic [MAX_PAT:0] nv;
    logic [CHAR_W-1:0] pb;
    n        = used_len();
    wild     = has_wildcards(n);
    fin      = 1 << n;
    hit      = 1'b0;
    produced = 1'b0;
    if (empty) begin
      hit      = |(start_prefixes(n) & fin);
      produced = 1'b1;
      restart_matcher();
    end else begin
      v  = wild ? close_stars(live_prefixes, n) : (live_prefixes | 1);
      nv = '0;
      for (int i = 0; i < n; i++) begin
        if (v[i]) begin
          pb = pattern_at(i);
          if (wild && pb == CHAR_STAR) begin
            nv[i] = 1'b1;
          end else if ((wild && pb == CHAR_QMARK) || lower_ascii(pb) == lower_ascii(ch)) begin
            nv[i+1] = 1'b1;
          end
        end
      end
      // containment: restart at every byte, and a found occurrence sticks
      nv = wild ? close_stars(nv, n) : (nv | 1 | (v & fin));
      if (last) begin
        hit      = |(nv & fin);
        produced = 1'b1;
        restart_matcher();
      end else begin
        live_prefixes = nv;
      end
    end
    return hit;
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------
  // Drive one item, hold it until accepted, then record what it should produce.
  task automatic send_item(input logic [CHAR_W-1:0] ch, input bit last, input bit empty,
                           input answer_e answer);
    int gap;
    bit produced;
    bit predicted;
    gap = no_idle ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    text_char_i  <= ch;
    last_char_i  <= last;
    empty_text_i <= empty;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predicted = step_matcher(ch, last, empty, produced);
    if (produced) begin
      match_expected_q.insert(match_expected_q.size(),
                              (answer == ANSWER_MODEL) ? predicted : (answer == ANSWER_YES));
    end
    items_sent++;
  endtask

  // Drop valid, wait out every pending result, then let the last item settle.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (match_expected_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Leave the write enable high; the caller lowers it after the last write.
  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    apply_write(idx, data);
  endtask

  task automatic load_pattern(input logic [CHAR_W-1:0] pbytes [MAX_PAT],
                              input logic [LEN_W-1:0] len_val);
    logic [CFG_DATA_W-1:0] w [NUM_WORDS];
    bit                    len_first;
    for (int k = 0; k < NUM_WORDS; k++) begin
      for (int j = 0; j < BYTES_PER_WORD; j++) begin
        w[k][j * CHAR_W +: CHAR_W] = pbytes[k * BYTES_PER_WORD + j];
      end
    end
    len_first = $urandom_range(0, 1);
    wait_idle();
    if (len_first) put_reg(REG_LEN, CFG_DATA_W'(len_val));
    put_reg(REG_WORD0, w[0]);
    put_reg(REG_WORD1, w[1]);
    put_reg(REG_WORD2, w[2]);
    put_reg(REG_WORD3, w[3]);
    if (!len_first) put_reg(REG_LEN, CFG_DATA_W'(len_val));
    cfg_we_i <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Random content
  // ---------------------------------------------------------------------------
  function automatic logic [CHAR_W-1:0] pick_char(input bit letters_only);
    return TEXT_ALPHABET[$urandom_range(0, letters_only ? NUM_LETTERS - 1
                                                         : TEXT_ALPHABET.len() - 1)];
  endfunction

  function automatic logic [CHAR_W-1:0] flip_case(input logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] lc;
    lc = c | CASE_DIFF;
    if (lc >= (CHAR_UC_A | CASE_DIFF) && lc <= (CHAR_UC_Z | CASE_DIFF) && $urandom_range(0, 1))
      return c ^ CASE_DIFF;
    return c;
  endfunction

  task automatic make_pattern(output logic [CHAR_W-1:0] pbytes [MAX_PAT],
                              output logic [LEN_W-1:0] len_val);
    int r;
    int q;
    int fill;
    bit wild;
    r    = $urandom_range(0, 19);
    fill = $urandom_range(0, 9);
    wild = ($urandom_range(0, 2) != 0);
    case (r)
      0:       len_val = '0;
      1:       len_val = LEN_W'(MAX_PAT);
      2:       len_val = LEN_W'($urandom_range(MAX_PAT + 1, (1 << LEN_W) - 1));
      default: len_val = LEN_W'((r < 16) ? $urandom_range(1, 8)
                                         : $urandom_range(9, MAX_PAT - 1));
    endcase
    for (int j = 0; j < MAX_PAT; j++) begin
      q = $urandom_range(0, 9);
      if (fill == 0) begin
        pbytes[j] = '1;
      end else if (fill == 1) begin
        pbytes[j] = '0;
      end else if (j >= len_val) begin
        pbytes[j] = CHAR_W'($urandom);   // garbage beyond the length
      end else if (wild && q < 3) begin
        pbytes[j] = CHAR_STAR;
      end else if (wild && q < 5) begin
        pbytes[j] = CHAR_QMARK;
      end else begin
        pbytes[j] = (q < 9) ? pick_char(1'b1) : CHAR_W'($urandom);
      end
    end
  endtask

  // Mostly texts built to fit the loaded pattern, then near misses and noise.
  task automatic make_text(output logic [CHAR_W-1:0] txt [$]);
    int                kind;
    int                n;
    bit                wild;
    logic [CHAR_W-1:0] pb;
    txt.delete();
    kind = $urandom_range(0, 9);
    if (kind < 6) begin
      n    = used_len();
      wild = has_wildcards(n);
      if (!wild) repeat ($urandom_range(0, 3)) txt.insert(txt.size(), pick_char(1'b1));
      for (int j = 0; j < n; j++) begin
        pb = pattern_at(j);
        if (wild && pb == CHAR_STAR) begin
          repeat ($urandom_range(0, 3)) txt.insert(txt.size(), pick_char(1'b0));
        end else if (wild && pb == CHAR_QMARK) begin
          txt.insert(txt.size(), CHAR_W'($urandom));
        end else begin
          txt.insert(txt.size(), flip_case(pb));
        end
      end
      if (!wild) repeat ($urandom_range(0, 3)) txt.insert(txt.size(), pick_char(1'b1));
      if ($urandom_range(0, 3) == 0 && txt.size() > 0) begin
        txt[$urandom_range(0, txt.size() - 1)] = pick_char(1'b0);
      end else if ($urandom_range(0, 7) == 0) begin
        txt.insert(txt.size(), pick_char(1'b0));
      end
    end else if (kind < 8) begin
      repeat ($urandom_range(0, 10)) txt.insert(txt.size(), pick_char(1'b0));
    end else if (kind < 9) begin
      repeat ($urandom_range(1, 6)) txt.insert(txt.size(), CHAR_W'($urandom));
    end
  endtask

  task automatic send_text(input logic [CHAR_W-1:0] txt [$]);
    if (txt.size() == 0) begin
      send_item(CHAR_W'($urandom), 1'($urandom), 1'b1, ANSWER_MODEL);
    end else begin
      foreach (txt[j]) send_item(txt[j], j == txt.size() - 1, 1'b0, ANSWER_MODEL);
    end
  endtask

  function automatic logic [CHAR_W-1:0] row_byte(input string s, input int j);
    return (s[j] == NUL_STANDIN) ? 8'h00 : s[j];
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: random stall before each result, compare on acceptance
  // ---------------------------------------------------------------------------
  initial begin
    int hold;
    bit expected;
    forever begin
      hold = no_idle ? 0 : $urandom_range(0, 3);
      if (hold != 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!(out_valid_o === 1'b1 && !out_stall_i));
      if (match_expected_q.size() == 0) begin
        report_mismatch($sformatf("result match=%0b with nothing expected", match_o));
      end else begin
        expected = match_expected_q.pop_front();
        if (match_o !== expected) begin
          report_mismatch($sformatf("match=%0b, expected %0b", match_o, expected));
        end
      end
    end
  end

  // Watchdog: end the run if the handshakes ever hang
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("wildcard_text_matcher_test NOT OK");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    logic [CHAR_W-1:0] pbytes [MAX_PAT];
    logic [LEN_W-1:0]  len_val;
    logic [CHAR_W-1:0] txt [$];
    int                random_start;
    int                ending;

    // Hold reset, then release it on a clock edge
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Walk the directed table
    foreach (stim_rows[r]) begin
      case (stim_rows[r].kind)
        ROW_PATTERN: begin
          foreach (pbytes[j]) pbytes[j] = '0;
          for (int j = 0; j < stim_rows[r].bytes.len(); j++) begin
            pbytes[j] = row_byte(stim_rows[r].bytes, j);
          end
          load_pattern(pbytes, LEN_W'(stim_rows[r].length));
        end
        ROW_TEXT, ROW_OPEN: begin
          for (int j = 0; j < stim_rows[r].bytes.len(); j++) begin
            send_item(row_byte(stim_rows[r].bytes, j),
                      stim_rows[r].kind == ROW_TEXT && j == stim_rows[r].bytes.len() - 1,
                      1'b0, stim_rows[r].answer);
          end
        end
        default: begin
          send_item(CHAR_W'($urandom), 1'($urandom), 1'b1, stim_rows[r].answer);
        end
      endcase
    end
    // close the last directed case: a non-ASCII byte against its folded twin
    send_item(8'hE1, 1'b1, 1'b0, ANSWER_NO);

    // Random phases: load a pattern, stream texts, sometimes leave one open
    random_start = items_sent;
    while (items_sent - random_start < RANDOM_ITEMS) begin
      no_idle = ($urandom_range(0, 4) == 0);
      make_pattern(pbytes, len_val);
      load_pattern(pbytes, len_val);
      repeat ($urandom_range(4, 14)) begin
        make_text(txt);
        send_text(txt);
      end
      ending = $urandom_range(0, 3);
      if (ending != 3) begin
        repeat ($urandom_range(1, 4)) send_item(pick_char(1'b0), 1'b0, 1'b0, ANSWER_MODEL);
      end
      case (ending)
        // 0: leave the text open; the next pattern load drops it
        1: send_item(CHAR_W'($urandom), 1'($urandom), 1'b1, ANSWER_MODEL);
        2: begin
          // a write to an unused index must not disturb the open text
          wait_idle();
          put_reg(FIRST_UNUSED_REG + CFG_IDX_W'($urandom_range(0, 2)), {$urandom, $urandom});
          cfg_we_i <= 1'b0;
          make_text(txt);
          if (txt.size() == 0) txt.insert(txt.size(), pick_char(1'b0));
          send_text(txt);
        end
        default: ;
      endcase
    end

    // Drain and let any stray result show up
    wait_idle();
    repeat (END_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("wildcard_text_matcher_test OK");
    end else begin
      $display("wildcard_text_matcher_test NOT OK");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/wtm_pkg.sv
rtl/core/wtm_cfg.sv
rtl/core/wtm_cell.sv
rtl/core/wildcard_text_matcher.sv
tb/wildcard_text_matcher_test.sv
